/* design/drss_pkg.sv */
package drss_pkg;

  // Filter geometry.
  localparam int WINDOW_LENGTH = 3;
  localparam int SAMPLE_BITS   = 12;
  localparam int POS_W         = $clog2(WINDOW_LENGTH);
  localparam int SUM_W         = SAMPLE_BITS + $clog2(WINDOW_LENGTH);

  // Division of the window sum by WINDOW_LENGTH is a multiply by a rounded-up
  // reciprocal; with this shift the quotient is exact over the whole sum range.
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / WINDOW_LENGTH + 64'd1);
  localparam int RPROD_W = SUM_W + RECIP_SHIFT;

  // Steering arithmetic.
  localparam int GAIN_W  = 8;
  localparam int DRIVE_W = 16;
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 1;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W  = 2 * SAMPLE_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * DRIVE_W + 2 * SAMPLE_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_CEILING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DRIVE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_CEILING  = 3'd4;

  // Pipeline load strobes handed to the lanes and to the merging stage.
  typedef struct packed {
    logic s1_load;  // an item is accepted: update ring, register sum
    logic s2_load;  // sum stage moves into the average register
  } lane_ctl_t;

  typedef struct packed {
    logic s3_load;  // averages move into the product stage
    logic s4_load;  // product stage moves into the output register
  } merge_ctl_t;

endpackage

/* design/drss_lane.sv */
module drss_lane
  import drss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_ctl_t              ctl,
  input  logic [POS_W-1:0]       pos,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] ceiling,
  output logic [SAMPLE_BITS-1:0] avg
);

  logic [SAMPLE_BITS-1:0] win_r   [WINDOW_LENGTH];
  logic [SAMPLE_BITS-1:0] win_nxt [WINDOW_LENGTH];
  logic [SAMPLE_BITS-1:0] clamped;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [RPROD_W-1:0]     rprod;
  logic [SAMPLE_BITS-1:0] avg_r;

  assign clamped = (sample > ceiling) ? ceiling : sample;

  // The new sample replaces the oldest entry; the sum covers the updated ring.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      win_nxt[i] = (pos == POS_W'(i)) ? clamped : win_r[i];
      sum_nxt    = sum_nxt + SUM_W'(win_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctl.s1_load) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      sum_r <= sum_nxt;
    end
  end

  assign rprod = RPROD_W'(sum_r) * RPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      avg_r <= rprod[RECIP_SHIFT +: SAMPLE_BITS];
    end
  end

  assign avg = avg_r;

endmodule

/* design/drss_merge.sv */
module drss_merge
  import drss_pkg::*;
(
  input  logic                   clk,
  input  merge_ctl_t             ctl,
  input  logic [SAMPLE_BITS-1:0] left_avg,
  input  logic [SAMPLE_BITS-1:0] right_avg,
  input  logic [GAIN_W-1:0]      gain,
  input  logic [DRIVE_W-1:0]     base,
  input  logic [DRIVE_W-1:0]     floor_val,
  input  logic [DRIVE_W-1:0]     ceil_val,
  output logic [DRIVE_W-1:0]     left_drive,
  output logic [DRIVE_W-1:0]     right_drive,
  output logic [SAMPLE_BITS-1:0] left_average,
  output logic [SAMPLE_BITS-1:0] right_average
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic [SAMPLE_BITS-1:0]   la_r;
  logic [SAMPLE_BITS-1:0]   ra_r;
  logic signed [ACC_W-1:0]  base_ext;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  left_acc;
  logic signed [ACC_W-1:0]  right_acc;
  logic [DRIVE_W-1:0]       ldrv_r;
  logic [DRIVE_W-1:0]       rdrv_r;
  logic [SAMPLE_BITS-1:0]   lavg_r;
  logic [SAMPLE_BITS-1:0]   ravg_r;

  // The ceiling test wins over the floor test when the two overlap.
  function automatic logic [DRIVE_W-1:0] clamp_drive(
    input logic signed [ACC_W-1:0] v,
    input logic [DRIVE_W-1:0]      lo,
    input logic [DRIVE_W-1:0]      hi
  );
    logic signed [ACC_W-1:0] lo_ext;
    logic signed [ACC_W-1:0] hi_ext;
    lo_ext = $signed({{(ACC_W-DRIVE_W){1'b0}}, lo});
    hi_ext = $signed({{(ACC_W-DRIVE_W){1'b0}}, hi});
    if (v > hi_ext) begin
      clamp_drive = hi;
    end else if (v < lo_ext) begin
      clamp_drive = lo;
    end else begin
      clamp_drive = v[DRIVE_W-1:0];
    end
  endfunction

  assign diff = $signed({1'b0, left_avg}) - $signed({1'b0, right_avg});
  assign prod = PROD_W'(diff) * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      prod_r <= prod;
      la_r   <= left_avg;
      ra_r   <= right_avg;
    end
  end

  assign base_ext  = $signed({{(ACC_W-DRIVE_W){1'b0}}, base});
  assign prod_ext  = {prod_r[PROD_W-1], prod_r};
  assign left_acc  = base_ext + prod_ext;
  assign right_acc = base_ext - prod_ext;

  always_ff @(posedge clk) begin
    if (ctl.s4_load) begin
      ldrv_r <= clamp_drive(left_acc, floor_val, ceil_val);
      rdrv_r <= clamp_drive(right_acc, floor_val, ceil_val);
      lavg_r <= la_r;
      ravg_r <= ra_r;
    end
  end

  assign left_drive    = ldrv_r;
  assign right_drive   = rdrv_r;
  assign left_average  = lavg_r;
  assign right_average = ravg_r;

endmodule

/* design/dual_range_sensor_steering_unit.sv */
// Dual range sensor steering unit.
// The input stream (in_tvalid, in_tready, in_tdata) carries one item per pair of
// distance readings, left and right. Each reading is clamped to the sensor ceiling,
// put into its own three-entry ring, and the ring mean is taken. The left-minus-
// right difference of the means, times the steering gain, is added to the base
// drive for the left motor and subtracted for the right motor; both drives are
// then clamped to the drive limits. The output stream (out_tvalid, out_tready,
// out_tdata) carries one item per input item with both drives and both means.
// The two sides run in parallel lanes and a merging stage forms the drives.
// Throughput is one item per cycle while the receiver takes items; the ring
// update and sum are done in the cycle an item is accepted, so one item can
// follow the next directly. The pipeline stages are the ring sum, the
// reciprocal multiply for the mean, the gain multiply, and the add and clamp.
// When the receiver stalls, the output register holds its item and each stage
// keeps accepting until the stage behind it is occupied.
// Reset clears the rings and the ring position to zero, empties the pipeline
// and loads the register defaults. The cfg_ port writes one register per cycle
// with cfg_we and should only be used while the block holds no items.
module dual_range_sensor_steering_unit
  import drss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] left_sample, [23:12] right_sample
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] left_drive, [31:16] right_drive, [43:32] left_average,
  // [55:44] right_average
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] sensor_ceiling_r;
  logic [GAIN_W-1:0]      steer_gain_r;
  logic [DRIVE_W-1:0]     base_drive_r;
  logic [DRIVE_W-1:0]     drive_floor_r;
  logic [DRIVE_W-1:0]     drive_ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_ceiling_r <= SAMPLE_BITS'(900);
      steer_gain_r     <= GAIN_W'(5);
      base_drive_r     <= DRIVE_W'(550);
      drive_floor_r    <= DRIVE_W'(500);
      drive_ceiling_r  <= DRIVE_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_CEILING: sensor_ceiling_r <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_STEER_GAIN:     steer_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_BASE_DRIVE:     base_drive_r     <= cfg_wdata[DRIVE_W-1:0];
        CFG_DRIVE_FLOOR:    drive_floor_r    <= cfg_wdata[DRIVE_W-1:0];
        CFG_DRIVE_CEILING:  drive_ceiling_r  <= cfg_wdata[DRIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline occupancy. A stage may load whenever it is empty or the stage
  // behind it loads in the same cycle.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;
  logic       accept;

  assign in_tready         = rdy1;
  assign accept            = in_tvalid && rdy1;
  assign lane_ctl.s1_load  = accept;
  assign lane_ctl.s2_load  = rdy2 && v1_r;
  assign merge_ctl.s3_load = rdy3 && v2_r;
  assign merge_ctl.s4_load = rdy4 && v3_r;

  // Ring position shared by both lanes; it moves on every accepted item.
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  assign pos_nxt = (pos_r == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  logic [SAMPLE_BITS-1:0] left_avg;
  logic [SAMPLE_BITS-1:0] right_avg;

  drss_lane u_left_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .pos     (pos_r),
    .sample  (in_tdata[SAMPLE_BITS-1:0]),
    .ceiling (sensor_ceiling_r),
    .avg     (left_avg)
  );

  drss_lane u_right_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .pos     (pos_r),
    .sample  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .ceiling (sensor_ceiling_r),
    .avg     (right_avg)
  );

  logic [DRIVE_W-1:0]     left_drive;
  logic [DRIVE_W-1:0]     right_drive;
  logic [SAMPLE_BITS-1:0] left_average;
  logic [SAMPLE_BITS-1:0] right_average;

  drss_merge u_merge (
    .clk           (clk),
    .ctl           (merge_ctl),
    .left_avg      (left_avg),
    .right_avg     (right_avg),
    .gain          (steer_gain_r),
    .base          (base_drive_r),
    .floor_val     (drive_floor_r),
    .ceil_val      (drive_ceiling_r),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .left_average  (left_average),
    .right_average (right_average)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                       right_average, left_average, right_drive, left_drive};

`ifndef SYNTH
  // The ring position never leaves the window.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(WINDOW_LENGTH))
    else $error("ring position out of range");

  // An accepted item always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted item lost at first stage");

  // With sane limits both delivered drives lie within them.
  a_drive_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (drive_floor_r <= drive_ceiling_r)) |->
      (left_drive >= drive_floor_r) && (left_drive <= drive_ceiling_r) &&
      (right_drive >= drive_floor_r) && (right_drive <= drive_ceiling_r))
    else $error("drive outside limits");
`endif

endmodule
